### hw/rtl/swmt_pkg.sv
// Shared types and constants for the sorted window median tracker.
package swmt_pkg;

  localparam int unsigned LVL_W             = 16;
  localparam int unsigned CNT_W             = 8;
  localparam int unsigned DEF_WINDOW_DEPTH  = 17;
  localparam logic [CNT_W-1:0] COUNT_LIMIT  = 8'd254;

  typedef logic signed [LVL_W-1:0] lvl_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // pair travelling along the row of cells
  typedef struct packed {
    logic vld;
    lvl_t lvl;
    lvl_t tmp;
  } carry_t;

endpackage

### hw/rtl/swmt_cell.sv
// One window slot: holds a level/temperature pair and passes carried pairs on.
module swmt_cell
  import swmt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  lvl_t   smp_lvl,
  input  carry_t rin,
  input  carry_t lin,
  output carry_t rout,
  output carry_t lout,
  output lvl_t   level_o,
  output lvl_t   temp_o,
  output logic   ge_o,
  output logic   le_o
);

  lvl_t   level_r;
  lvl_t   temp_r;
  carry_t rout_r;
  carry_t lout_r;
  logic   empty;

  assign empty = (level_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      temp_r     <= '0;
      rout_r.vld <= 1'b0;
      lout_r.vld <= 1'b0;
    end else begin
      if (rin.vld) begin
        level_r <= rin.lvl;
        temp_r  <= rin.tmp;
      end else if (lin.vld) begin
        level_r <= lin.lvl;
        temp_r  <= lin.tmp;
      end
      // an empty slot swallows nothing: the carried pair moves on unchanged
      rout_r.vld <= rin.vld;
      rout_r.lvl <= empty ? rin.lvl : level_r;
      rout_r.tmp <= empty ? rin.tmp : temp_r;
      lout_r.vld <= lin.vld;
      lout_r.lvl <= empty ? lin.lvl : level_r;
      lout_r.tmp <= empty ? lin.tmp : temp_r;
    end
  end

  assign rout    = rout_r;
  assign lout    = lout_r;
  assign level_o = level_r;
  assign temp_o  = temp_r;
  assign ge_o    = (smp_lvl >= level_r);
  assign le_o    = (smp_lvl <= level_r);

endmodule

### hw/rtl/sorted_window_median_tracker.sv
// Sorted window median tracker: top level with control and the row of cells.
// A valid sample passes S_SEARCH and S_SHIFT before S_DONE loads its result; an ignored
// one (invalid or count full) goes straight to S_DONE. Requests are taken in S_IDLE only,
// after the carried pair has walked the row one cell per cycle and S_DONE, which waits on
// an untaken result, has reloaded the output register; a finished result may wait there
// while the next request is taken. Sync active-low reset empties all.
module sorted_window_median_tracker
  import swmt_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] level, [31:16] temperature
  input  logic [0:0]  in_tuser,   // [0] invalid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [15:0] median_level, [31:16] median_temperature,
                                  // [39:32] sample_count
);

  localparam int unsigned MID  = WINDOW_DEPTH / 2;
  localparam int unsigned SC_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_DONE} state_t;

  state_t            state_r;
  logic [SC_W-1:0]   shift_cnt_r;
  cnt_t              count_r;
  lvl_t              smp_lvl_r;
  lvl_t              smp_tmp_r;
  logic              ins_r;
  logic              out_tvalid_r;
  logic [39:0]       out_tdata_r;

  // row signals
  carry_t            rin   [WINDOW_DEPTH];
  carry_t            lin   [WINDOW_DEPTH];
  carry_t            rout  [WINDOW_DEPTH];
  carry_t            lout  [WINDOW_DEPTH];
  lvl_t              lvl_w [WINDOW_DEPTH];
  lvl_t              tmp_w [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] ge;
  logic [WINDOW_DEPTH-1:0] le;
  logic [WINDOW_DEPTH-1:0] inj_r;
  logic [WINDOW_DEPTH-1:0] inj_l;
  logic [WINDOW_DEPTH-1:0] hit_lo;
  logic [WINDOW_DEPTH-1:0] hit_hi;
  logic              found_lo;
  logic              found_hi;
  logic              go;
  logic              in_acc;
  carry_t            smp;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign go        = (state_r == S_SEARCH) && ins_r;
  assign smp       = '{vld: 1'b1, lvl: smp_lvl_r, tmp: smp_tmp_r};

  // Find the gap for the sample. Below the middle the search runs from the middle
  // down, above it from the middle up; the first gap found wins.
  always_comb begin
    hit_lo   = '0;
    hit_hi   = '0;
    found_lo = 1'b0;
    found_hi = 1'b0;
    for (int i = MID; i > 0; i--) begin
      hit_lo[i] = ge[i-1] && le[i] && !found_lo;
      found_lo  = found_lo || (ge[i-1] && le[i]);
    end
    for (int i = MID; i < WINDOW_DEPTH - 1; i++) begin
      hit_hi[i] = ge[i] && le[i+1] && !found_hi;
      found_hi  = found_hi || (ge[i] && le[i+1]);
    end
  end

  // where the carried pairs start
  always_comb begin
    inj_r = '0;
    inj_l = '0;
    if (go) begin
      if (!ge[MID]) begin
        // smaller than the middle: shift right, last entry falls off
        if (found_lo) inj_r = hit_lo;
        else          inj_r[0] = 1'b1;
      end else if (!le[MID]) begin
        // larger than the middle: shift left, first entry falls off
        if (found_hi) inj_l = hit_hi;
        else          inj_l[WINDOW_DEPTH-1] = 1'b1;
      end else begin
        // equal: both ways from the middle
        inj_r[MID]   = 1'b1;
        inj_l[MID-1] = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_row
    if (g == 0) begin : g_first
      assign rin[g] = inj_r[g] ? smp : carry_t'('0);
    end else begin : g_rest
      assign rin[g] = inj_r[g] ? smp : rout[g-1];
    end
    if (g == WINDOW_DEPTH - 1) begin : g_last
      assign lin[g] = inj_l[g] ? smp : carry_t'('0);
    end else begin : g_inner
      assign lin[g] = inj_l[g] ? smp : lout[g+1];
    end

    swmt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .smp_lvl (smp_lvl_r),
      .rin     (rin[g]),
      .lin     (lin[g]),
      .rout    (rout[g]),
      .lout    (lout[g]),
      .level_o (lvl_w[g]),
      .temp_o  (tmp_w[g]),
      .ge_o    (ge[g]),
      .le_o    (le[g])
    );
  end

  // sample capture, sequencing and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      shift_cnt_r  <= '0;
      count_r      <= '0;
      ins_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            smp_lvl_r <= in_tdata[15:0];
            smp_tmp_r <= in_tdata[31:16];
            ins_r     <= !in_tuser[0] && (count_r <= COUNT_LIMIT);
            state_r   <= (!in_tuser[0] && (count_r <= COUNT_LIMIT)) ? S_SEARCH : S_DONE;
          end
        end
        S_SEARCH: begin
          count_r     <= count_r + cnt_t'(1);
          shift_cnt_r <= '0;
          state_r     <= S_SHIFT;
        end
        S_SHIFT: begin
          if (shift_cnt_r == SC_W'(WINDOW_DEPTH - 1)) state_r <= S_DONE;
          shift_cnt_r <= shift_cnt_r + SC_W'(1);
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {count_r, tmp_w[MID], lvl_w[MID]};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### hw/rtl/swmt_checker.sv
// Port-level checks for the sorted window median tracker, bound to the top level.
module swmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with nothing inserted the window is still empty
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[39:32] == 8'd0) |-> (out_tdata[31:0] == 32'd0))
    else $error("non-empty median with zero count");

endmodule

bind sorted_window_median_tracker swmt_checker u_swmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
